@@ sv/nmu_pkg.sv @@
// shared types, constants and helpers of the nesterov momentum update block
`default_nettype none

package nmu_pkg;

  localparam int unsigned IdxW     = 12;
  localparam int unsigned ValW     = 32;
  localparam int unsigned LrW      = 24;
  localparam int unsigned MomW     = 16;
  localparam int unsigned SatInW   = 42;
  localparam int unsigned InDataW  = 80;
  localparam int unsigned ResW     = IdxW + ValW;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned CfgIdxW  = 1;

  localparam int unsigned NumElementsDef = 4096;

  localparam logic [LrW-1:0]  LrReset  = 24'd655;
  localparam logic [MomW-1:0] MomReset = 16'd58982;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLearningRate = 1'b0,
    CfgMomentum     = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic adv;
    logic accept;
    logic clear;
  } ctrl_t;

  typedef struct packed {
    logic            valid;
    logic            ok;
    logic [IdxW-1:0] idx;
  } s1_info_t;

  function automatic logic signed [ValW-1:0] sat32(input logic signed [SatInW-1:0] x);
    logic signed [ValW-1:0] r;
    if ((&x[SatInW-1:ValW-1]) || !(|x[SatInW-1:ValW-1])) begin
      r = x[ValW-1:0];
    end else if (x[SatInW-1]) begin
      r = {1'b1, {(ValW-1){1'b0}}};
    end else begin
      r = {1'b0, {(ValW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/nmu_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module nmu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/nmu_core.sv @@
// update pipeline: velocity read, forwarding, multiply stages, write back
`default_nettype none

module nmu_core import nmu_pkg::*; #(
  parameter int unsigned NUM_ELEMENTS = NumElementsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ctrl_t                 ctrl_i,
  input  wire logic [((NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1)-1:0] clr_addr_i,
  input  wire logic [LrW-1:0]        lr_i,
  input  wire logic [MomW-1:0]       mom_i,
  input  wire logic [InDataW-1:0]    in_data_i,
  output s1_info_t                   s1_info_o,
  output logic                       res_valid_o,
  output logic [ResW-1:0]            res_data_o
);

  localparam int unsigned AW    = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam int unsigned LgpW  = LrW + 1 + ValW;
  localparam int unsigned MvpW  = MomW + 1 + ValW;
  localparam int unsigned KvpW  = MomW + 2 + ValW;
  localparam int unsigned MvW   = MvpW - 16;
  localparam int unsigned LgW   = LgpW - 16;
  localparam int unsigned KvW   = KvpW - 16;

  logic [IdxW-1:0]          in_idx;
  logic signed [ValW-1:0]   in_p;
  logic signed [ValW-1:0]   in_g;
  logic                     in_ok;
  logic [AW+IdxW-1:0]       in_ext;
  logic [AW-1:0]            in_addr;
  logic signed [LgpW-1:0]   in_lgp;

  assign in_idx  = in_data_i[IdxW-1:0];
  assign in_p    = $signed(in_data_i[IdxW+ValW-1:IdxW]);
  assign in_g    = $signed(in_data_i[IdxW+2*ValW-1:IdxW+ValW]);
  assign in_ok   = 32'(in_idx) < 32'(NUM_ELEMENTS);
  assign in_ext  = {{AW{1'b0}}, in_idx};
  assign in_addr = in_ext[AW-1:0];
  assign in_lgp  = $signed({1'b0, lr_i}) * in_g;

  // stage registers
  logic                   s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic                   s1_ok_q, s2_ok_q, s3_ok_q;
  logic [IdxW-1:0]        s1_idx_q, s2_idx_q, s3_idx_q, s4_idx_q;
  logic [AW-1:0]          s1_addr_q, s2_addr_q;
  logic signed [ValW-1:0] s1_p_q, s2_p_q, s3_p_q, s4_p_q;
  logic signed [LgpW-1:0] s1_lgp_q, s2_lgp_q;
  logic signed [MvpW-1:0] s2_mvp_q;
  logic signed [MvW-1:0]  s3_mv_q, s4_mv_q;
  logic signed [ValW-1:0] s3_vn_q;
  logic signed [KvpW-1:0] s4_kvp_q;

  logic [ValW-1:0]        rdata;
  logic                   s3_hit;
  logic signed [ValW-1:0] s1_v;
  logic signed [MvpW-1:0] s1_mvp;
  logic signed [MvW-1:0]  s2_mv;
  logic signed [LgW-1:0]  s2_lg;
  logic signed [SatInW-1:0] s2_diff;
  logic signed [ValW-1:0] s2_vn;
  logic signed [KvpW-1:0] s3_kvp;
  logic signed [KvW-1:0]  s4_kv;
  logic signed [SatInW-1:0] s4_sum;
  logic signed [ValW-1:0] s4_pn;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [ValW-1:0]        ram_wdata;

  assign ram_we    = ctrl_i.clear || (ctrl_i.adv && s2_valid_q && s2_ok_q);
  assign ram_waddr = ctrl_i.clear ? clr_addr_i : s2_addr_q;
  assign ram_wdata = ctrl_i.clear ? '0 : s2_vn;

  nmu_ram #(
    .Width (ValW),
    .Depth (NUM_ELEMENTS)
  ) u_vel_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ctrl_i.accept),
    .raddr_i (in_addr),
    .rdata_o (rdata)
  );

  // stage three wrote back from stage two on the same edge as the read
  assign s3_hit = s3_valid_q && s3_ok_q && (s3_idx_q == s1_idx_q);
  assign s1_v   = !s1_ok_q ? '0 : (s3_hit ? s3_vn_q : $signed(rdata));
  assign s1_mvp = $signed({1'b0, mom_i}) * s1_v;

  assign s2_mv   = $signed(s2_mvp_q[MvpW-1:16]);
  assign s2_lg   = $signed(s2_lgp_q[LgpW-1:16]);
  assign s2_diff = $signed({{(SatInW-MvW){s2_mv[MvW-1]}}, s2_mv})
                 - $signed({{(SatInW-LgW){s2_lg[LgW-1]}}, s2_lg});
  assign s2_vn   = sat32(s2_diff);

  assign s3_kvp = $signed({2'b01, mom_i}) * s3_vn_q;

  assign s4_kv  = $signed(s4_kvp_q[KvpW-1:16]);
  assign s4_sum = $signed({{(SatInW-ValW){s4_p_q[ValW-1]}}, s4_p_q})
                - $signed({{(SatInW-MvW){s4_mv_q[MvW-1]}}, s4_mv_q})
                + $signed({{(SatInW-KvW){s4_kv[KvW-1]}}, s4_kv});
  assign s4_pn  = sat32(s4_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (ctrl_i.adv) begin
      s1_valid_q <= ctrl_i.accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      s1_ok_q   <= in_ok;
      s1_idx_q  <= in_idx;
      s1_addr_q <= in_addr;
      s1_p_q    <= in_p;
      s1_lgp_q  <= in_lgp;

      s2_ok_q   <= s1_ok_q;
      s2_idx_q  <= s1_idx_q;
      s2_addr_q <= s1_addr_q;
      s2_p_q    <= s1_p_q;
      s2_lgp_q  <= s1_lgp_q;
      s2_mvp_q  <= s1_mvp;

      s3_ok_q   <= s2_ok_q;
      s3_idx_q  <= s2_idx_q;
      s3_p_q    <= s2_p_q;
      s3_mv_q   <= s2_mv;
      s3_vn_q   <= s2_vn;

      s4_idx_q  <= s3_idx_q;
      s4_p_q    <= s3_p_q;
      s4_mv_q   <= s3_mv_q;
      s4_kvp_q  <= s3_kvp;
    end
  end

  assign s1_info_o.valid = s1_valid_q;
  assign s1_info_o.ok    = s1_ok_q;
  assign s1_info_o.idx   = s1_idx_q;

  assign res_valid_o = s4_valid_q;
  assign res_data_o  = {s4_pn, s4_idx_q};

endmodule

`default_nettype wire

@@ sv/nmu_out_buf.sv @@
// output register with skid stage for the result stream
`default_nettype none

module nmu_out_buf import nmu_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic [ResW-1:0]     in_data_i,
  output logic                     adv_o,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata
);

  logic            o_valid_q, k_valid_q;
  logic [ResW-1:0] o_data_q, k_data_q;
  logic            pop, push;

  assign adv_o = !k_valid_q;
  assign pop   = o_valid_q && m_axis_tready;
  assign push  = in_valid_i && !k_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      k_valid_q <= 1'b0;
    end else if (pop) begin
      if (k_valid_q) begin
        k_valid_q <= 1'b0;
      end else begin
        o_valid_q <= push;
      end
    end else if (push) begin
      if (o_valid_q) begin
        k_valid_q <= 1'b1;
      end else begin
        o_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (k_valid_q) begin
        o_data_q <= k_data_q;
      end else if (push) begin
        o_data_q <= in_data_i;
      end
    end else if (push) begin
      if (o_valid_q) begin
        k_data_q <= in_data_i;
      end else begin
        o_data_q <= in_data_i;
      end
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = {{(OutDataW-ResW){1'b0}}, o_data_q};

endmodule

`default_nettype wire

@@ sv/nesterov_momentum_update_top.sv @@
// path: an accepted request passes the core stage registers, then the output register
// throughput: one request per cycle unless the output buffer stalls; a request whose
//   element matches the one accepted just before waits for the velocity rmw loop
// reset: velocity ram cleared by a pass over all NUM_ELEMENTS entries, no request taken
//   meanwhile; learning_rate resets to 655 and momentum to 58982
// top level of the nesterov momentum update block
`default_nettype none

module nesterov_momentum_update_top import nmu_pkg::*; #(
  parameter int unsigned NUM_ELEMENTS = NumElementsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // element_index, param_value, gradient
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // element_out, new_param
  output logic [OutDataW-1:0]      m_axis_tdata,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [LrW-1:0]      cfg_data_i
);

  localparam int unsigned AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;

  typedef enum logic [1:0] {
    StClear = 2'b01,
    StRun   = 2'b10
  } clr_state_e;

  clr_state_e      state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [LrW-1:0]  lr_q;
  logic [MomW-1:0] mom_q;
  ctrl_t           ctrl;
  s1_info_t        s1_info;
  logic            adv;
  logic            hazard;
  logic            res_valid;
  logic [ResW-1:0] res_data;

  // clearing pass
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      StClear: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(NUM_ELEMENTS - 1)) begin
          state_d = StRun;
        end
      end
      StRun: begin
        clr_d = clr_q;
      end
      default: begin
        state_d = StClear;
        clr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q  <= LrReset;
      mom_q <= MomReset;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgLearningRate: lr_q  <= cfg_data_i;
        CfgMomentum:     mom_q <= cfg_data_i[MomW-1:0];
        default: ;
      endcase
    end
  end

  // same element right behind: wait for its write back to be forwardable
  assign hazard = s1_info.valid && s1_info.ok && (s1_info.idx == s_axis_tdata[IdxW-1:0]);

  assign s_axis_tready = adv && (state_q == StRun) && !hazard;
  assign ctrl.adv      = adv;
  assign ctrl.accept   = s_axis_tvalid && s_axis_tready;
  assign ctrl.clear    = (state_q == StClear);

  nmu_core #(
    .NUM_ELEMENTS (NUM_ELEMENTS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .clr_addr_i  (clr_q),
    .lr_i        (lr_q),
    .mom_i       (mom_q),
    .in_data_i   (s_axis_tdata),
    .s1_info_o   (s1_info),
    .res_valid_o (res_valid),
    .res_data_o  (res_data)
  );

  nmu_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (res_valid),
    .in_data_i     (res_data),
    .adv_o         (adv),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire
